/* sv/lhp_pkg.sv */
package lhp_pkg;

	// default number of the top bucket (samples of this bit length and above)
	localparam int unsigned TOP_BUCKET_DEF = 32;

	// fixed-point one for the fraction field
	localparam logic [16:0] FRAC_ONE = 17'h10000;

	// request codes
	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// bit length of a 64-bit value, 0 to 64
	localparam int unsigned LEN_W = 7;

	// multiplier operand and product widths
	localparam int unsigned FRAC_W = 17;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned PROD_W = FRAC_W + HALF_W;

	typedef struct packed {
		logic        req_type;
		logic [63:0] sample;
		logic [16:0] fraction;
	} req_t;

	typedef struct packed {
		logic [63:0] percentile_value;
		logic [63:0] total_count;
		logic [63:0] max_seen;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CNT,
		ST_MAX,
		ST_BLEN,
		ST_BRD,
		ST_BINC,
		ST_QCHK,
		ST_MHI,
		ST_MLO,
		ST_TGT,
		ST_SRD,
		ST_SACC
	} state_t;

endpackage

/* sv/log2_histogram_percentile.sv */
// channel | ports             | handshake
// request | req (req_t)       | taken at clk edge with start high and busy low
// result  | rsp (rsp_t)       | valid for the single cycle that done is high
//
// an add item updates count, max and one bucket before busy falls; the bit-length
// search runs six steps and the bucket update is a read then a write
// a query item ends at the count check when empty, else runs two multiply steps,
// a target step and up to TOP_BUCKET+1 buckets, each one memory read and one adder pass
// reset clears the counters and the bucket valid bits at once, no clearing pass
// the receiver cannot stall: done is high for one cycle per query item
module log2_histogram_percentile #(
	parameter int unsigned TOP_BUCKET = lhp_pkg::TOP_BUCKET_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lhp_pkg::req_t  req,
	output logic           done,
	output lhp_pkg::rsp_t  rsp
);
	import lhp_pkg::*;

	localparam int unsigned DEPTH = TOP_BUCKET + 1;
	localparam int unsigned IW    = $clog2(DEPTH);
	localparam logic [IW-1:0]    IDX_TOP = IW'(TOP_BUCKET);
	localparam logic [LEN_W-1:0] LEN_TOP = LEN_W'(TOP_BUCKET);

	state_t state_q, state_d;

	req_t               req_q;
	logic [63:0]        count_q;
	logic [63:0]        largest_q;
	logic [IW-1:0]      idx_q;
	logic [63:0]        acc_q;
	logic [63:0]        target_q;
	logic [PROD_W-1:0]  p_hi_q;
	logic [PROD_W-1:0]  p_lo_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               blen_load;
	logic               blen_done;
	logic [LEN_W-1:0]   blen_len;
	logic [LEN_W-1:0]   len_clamp;

	logic [63:0]        alu_a, alu_b, alu_c, alu_sum;
	logic               alu_gt;
	logic [FRAC_W-1:0]  mul_f;
	logic [HALF_W-1:0]  mul_c;
	logic [PROD_W-1:0]  prod;

	logic [IW-1:0]      raddr;
	logic [63:0]        rdata;
	logic               we;

	logic               emit;
	logic [63:0]        emit_value;
	logic [FRAC_W-1:0]  frac_sat;

	assign accept    = (state_q == ST_IDLE) && start;
	assign blen_load = accept && (req.req_type == REQ_ADD);
	assign busy      = (state_q != ST_IDLE);

	// fractions above one saturate to one
	assign frac_sat  = (req_q.fraction > FRAC_ONE) ? FRAC_ONE : req_q.fraction;
	assign len_clamp = (blen_len > LEN_TOP) ? LEN_TOP : blen_len;

	lhp_blen u_blen (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (blen_load),
		.value  (req.sample),
		.done   (blen_done),
		.len    (blen_len)
	);

	lhp_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.c     (alu_c),
		.mul_f (mul_f),
		.mul_c (mul_c),
		.sum   (alu_sum),
		.gt    (alu_gt),
		.prod  (prod)
	);

	lhp_bank #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (raddr),
		.rdata  (rdata),
		.we     (we),
		.waddr  (idx_q),
		.wdata  (alu_sum)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (req.req_type == REQ_ADD) ? ST_CNT : ST_QCHK;
				end
			end
			ST_CNT:  state_d = ST_MAX;
			ST_MAX:  state_d = ST_BLEN;
			ST_BLEN: begin
				if (blen_done) begin
					state_d = ST_BRD;
				end
			end
			ST_BRD:  state_d = ST_BINC;
			ST_BINC: state_d = ST_IDLE;
			ST_QCHK: state_d = (count_q == 64'd0) ? ST_IDLE : ST_MHI;
			ST_MHI:  state_d = ST_MLO;
			ST_MLO:  state_d = ST_TGT;
			ST_TGT:  state_d = ST_SRD;
			ST_SRD:  state_d = ST_SACC;
			ST_SACC: begin
				if (alu_gt || idx_q == IDX_TOP) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// operand selection and control outputs
	always_comb begin
		alu_a      = acc_q;
		alu_b      = rdata;
		alu_c      = target_q;
		mul_f      = frac_sat;
		mul_c      = count_q[31:0];
		raddr      = idx_q;
		we         = 1'b0;
		emit       = 1'b0;
		emit_value = largest_q;
		unique case (state_q)
			ST_CNT: begin
				alu_a = count_q;
				alu_b = 64'd1;
				alu_c = 64'd0;
			end
			ST_MAX: begin
				alu_a = req_q.sample;
				alu_b = 64'd0;
				alu_c = largest_q;
			end
			ST_BINC: begin
				alu_a = rdata;
				alu_b = 64'd1;
				alu_c = 64'd0;
				we    = 1'b1;
			end
			ST_QCHK: begin
				if (count_q == 64'd0) begin
					emit       = 1'b1;
					emit_value = 64'd0;
				end
			end
			ST_MHI: begin
				mul_c = count_q[63:32];
			end
			ST_TGT: begin
				alu_a = 64'(p_hi_q) << 16;
				alu_b = 64'(p_lo_q >> 16);
				alu_c = 64'd0;
			end
			ST_SACC: begin
				if (alu_gt) begin
					emit = 1'b1;
					if (idx_q == '0) begin
						emit_value = 64'd0;
					end else begin
						emit_value = 64'd1 << (idx_q - IW'(1));
					end
				end else if (idx_q == IDX_TOP) begin
					emit = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers and histogram totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= 64'd0;
			largest_q <= 64'd0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (state_q == ST_CNT) begin
				count_q <= alu_sum;
			end
			if (state_q == ST_MAX && alu_gt) begin
				largest_q <= req_q.sample;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == ST_BLEN && blen_done) begin
			idx_q <= IW'(len_clamp);
		end
		if (state_q == ST_MHI) begin
			p_hi_q <= prod;
		end
		if (state_q == ST_MLO) begin
			p_lo_q <= prod;
		end
		if (state_q == ST_TGT) begin
			target_q <= alu_sum;
			acc_q    <= 64'd0;
			idx_q    <= '0;
		end
		if (state_q == ST_SACC) begin
			acc_q <= alu_sum;
			if (!alu_gt && idx_q != IDX_TOP) begin
				idx_q <= idx_q + IW'(1);
			end
		end
		if (emit) begin
			rsp_q.percentile_value <= emit_value;
			rsp_q.total_count      <= count_q;
			rsp_q.max_seen         <= largest_q;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* sv/lhp_alu.sv */
module lhp_alu (
	input  logic [63:0]                  a,
	input  logic [63:0]                  b,
	input  logic [63:0]                  c,
	input  logic [lhp_pkg::FRAC_W-1:0]   mul_f,
	input  logic [lhp_pkg::HALF_W-1:0]   mul_c,
	output logic [63:0]                  sum,
	output logic                         gt,
	output logic [lhp_pkg::PROD_W-1:0]   prod
);
	import lhp_pkg::*;

	// shared adder with compare of its sum against a third operand
	assign sum = a + b;
	assign gt  = sum > c;

	// shared narrow multiplier, fraction times one count half
	assign prod = PROD_W'(mul_f) * PROD_W'(mul_c);

endmodule

/* sv/lhp_blen.sv */
module lhp_blen (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [63:0]                 value,
	output logic                        done,
	output logic [lhp_pkg::LEN_W-1:0]   len
);
	import lhp_pkg::*;

	localparam int unsigned STEPS = 6;
	localparam logic [2:0]  LAST  = 3'(STEPS - 1);

	logic [63:0]      v_q;
	logic [LEN_W-1:0] n_q;
	logic [2:0]       step_q;
	logic             run_q;
	logic             done_q;

	logic [LEN_W-1:0] half;
	logic [63:0]      upper;

	// binary search step: halve the window each cycle
	assign half  = LEN_W'(32) >> step_q;
	assign upper = v_q >> half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (load) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == LAST) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		if (load) begin
			v_q <= value;
			n_q <= '0;
		end else if (run_q && upper != 64'd0) begin
			v_q <= upper;
			n_q <= n_q + half;
		end
	end

	// residue is 0 or 1 once the search ends
	assign len  = n_q + LEN_W'(v_q[0]);
	assign done = done_q;

endmodule

/* sv/lhp_bank.sv */
module lhp_bank #(
	parameter int unsigned DEPTH = 33,
	parameter int unsigned IW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] raddr,
	output logic [63:0]   rdata,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [63:0]   wdata
);

	logic [63:0]      mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [63:0]      rdata_q;
	logic             rvld_q;

	// bucket storage, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// valid bits stand in for clearing the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	// an unwritten bucket reads as zero
	assign rdata = rvld_q ? rdata_q : 64'd0;

endmodule
